// ===== hdl/bkc_pkg.sv =====
// ----------------------------------------------------------------------------
// bkc_pkg: shared types and constants
// Widths, register indexes, border codes and the control bundle of the
// 3x3 convolution datapath.
// ----------------------------------------------------------------------------
package bkc_pkg;

  localparam int KERNEL_SIZE    = 3;
  localparam int MAX_WIDTH      = 1024;
  localparam int COEF_FRAC_BITS = 8;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int NTAPS   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int WREG_W  = 11;
  localparam int HREG_W  = 13;
  localparam int ICOL_W  = ADDR_W + 1;
  localparam int IROW_W  = HREG_W + 1;
  localparam int OROW_W  = HREG_W;
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam int SUM_W   = PROD_W + $clog2(NTAPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;

  localparam logic [1:0] BM_ZERO   = 2'd0;
  localparam logic [1:0] BM_REPL   = 2'd1;
  localparam logic [1:0] BM_MIRROR = 2'd2;

  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bot;
    logic lok;
    logic rok;
  } bkc_ctl_t;

endpackage

// ===== hdl/bkc_line_store.sv =====
// ----------------------------------------------------------------------------
// bkc_line_store: two previous rows
// One word per column holds the two rows above; registered read.
// ----------------------------------------------------------------------------
module bkc_line_store (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [bkc_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [2*bkc_pkg::PIX_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [bkc_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [2*bkc_pkg::PIX_W-1:0] wr_data_i
);
  import bkc_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/bkc_cell.sv =====
// ----------------------------------------------------------------------------
// bkc_cell: window column cell
// Holds one three-pixel column and hands it to the next cell.
// ----------------------------------------------------------------------------
module bkc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  bkc_pkg::pix_col_t col_i,
  output bkc_pkg::pix_col_t col_o
);
  import bkc_pkg::*;

  pix_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hdl/bkc_kernel.sv =====
// ----------------------------------------------------------------------------
// bkc_kernel: border fill and weighted sum
// Fill missing rows then columns, register nine products, sum and clamp.
// ----------------------------------------------------------------------------
module bkc_kernel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  bkc_pkg::bkc_ctl_t            ctl_i,
  input  bkc_pkg::pix_col_t            lcol_i,
  input  bkc_pkg::pix_col_t            ccol_i,
  input  bkc_pkg::pix_col_t            rcol_i,
  input  logic [63:0]                  coef_low_i,
  input  logic [63:0]                  coef_mid_i,
  input  logic [bkc_pkg::COEF_W-1:0]   coef_last_i,
  input  logic [1:0]                   mode_i,
  output logic                         valid_o,
  output logic                         last_o,
  output logic [bkc_pkg::PIX_W-1:0]    pixel_o
);
  import bkc_pkg::*;

  logic [NTAPS*COEF_W-1:0]           coefs;
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] lv, cv, rv, lp, rp;
  logic signed [PROD_W-1:0]          prod_d [NTAPS];
  logic signed [PROD_W-1:0]          prod_q [NTAPS];
  logic                              valid_q, last_q;
  logic signed [SUM_W-1:0]           sum;
  logic [SUM_W-COEF_FRAC_BITS-1:0]   quot;

  function automatic logic [PIX_W-1:0] pad(input logic [1:0] mode,
                                           input logic [PIX_W-1:0] same,
                                           input logic [PIX_W-1:0] opp);
    case (mode)
      BM_REPL:   pad = same;
      BM_MIRROR: pad = opp;
      default:   pad = '0;
    endcase
  endfunction

  function automatic pix_col_t vert(input logic [1:0] mode, input pix_col_t c,
                                    input logic top, input logic bot);
    pix_col_t v;
    v[1] = c[1];
    v[0] = top ? pad(mode, c[1], c[2]) : c[0];
    v[2] = bot ? pad(mode, c[1], c[0]) : c[2];
    vert = v;
  endfunction

  assign coefs = {coef_last_i, coef_mid_i, coef_low_i};

  always_comb begin
    lv = vert(mode_i, lcol_i, ctl_i.top, ctl_i.bot);
    cv = vert(mode_i, ccol_i, ctl_i.top, ctl_i.bot);
    rv = vert(mode_i, rcol_i, ctl_i.top, ctl_i.bot);
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      lp[i] = ctl_i.lok ? lv[i] : pad(mode_i, cv[i], rv[i]);
      rp[i] = ctl_i.rok ? rv[i] : pad(mode_i, cv[i], lp[i]);
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      prod_d[i*3]     = $signed(coefs[(i*3)*COEF_W +: COEF_W]) *
                        $signed({1'b0, lp[i]});
      prod_d[i*3 + 1] = $signed(coefs[(i*3+1)*COEF_W +: COEF_W]) *
                        $signed({1'b0, cv[i]});
      prod_d[i*3 + 2] = $signed(coefs[(i*3+2)*COEF_W +: COEF_W]) *
                        $signed({1'b0, rp[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && ctl_i.emit;
      last_q  <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NTAPS; k++) begin
      sum = sum + SUM_W'(prod_q[k]);
    end
    quot = sum[SUM_W-1:COEF_FRAC_BITS];
    if (sum[SUM_W-1]) begin
      pixel_o = '0;
    end else if (quot > (SUM_W-COEF_FRAC_BITS)'(255)) begin
      pixel_o = 8'd255;
    end else begin
      pixel_o = quot[PIX_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign last_o  = last_q;

endmodule

// ===== hdl/bordered_kernel_convolution_unit.sv =====
// ----------------------------------------------------------------------------
// bordered_kernel_convolution_unit: streaming 3x3 convolution
// Raster pixels in, 3x3 filtered pixels out with zero, replicate or mirror
// borders.
// ----------------------------------------------------------------------------
// One item per clock, back to back, while m_axis_tready is high or no
// output is held. Steps: line store read, border fill with nine multiplies,
// then the sum and clamp into the output register. Output pixel p leaves
// with input item p+width+1; after the last pixel, width+1 more items (any,
// flush or not) drain the frame, the last output carrying tlast. A flush
// item inside the frame is taken and dropped. Write configuration only
// while idle; a width or height write restarts the frame.
module bordered_kernel_convolution_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bkc_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
  input  logic                           s_axis_tuser,   // [0] flush
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bkc_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
  output logic                           m_axis_tlast,   // frame_end
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bkc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bkc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bkc_pkg::*;

  logic [63:0]       coef_low_q, coef_mid_q;
  logic [COEF_W-1:0] coef_last_q;
  logic [1:0]        mode_q;
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;

  logic [IROW_W-1:0] in_row_q, in_row_d;
  logic [ICOL_W-1:0] in_col_q, in_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [ADDR_W-1:0] out_col_q, out_col_d;

  logic              en, fire, act, in_frame;
  logic [ADDR_W-1:0] c;
  logic [PIX_W-1:0]  pix;
  logic [ICOL_W-1:0] c_inc;
  logic [ICOL_W-1:0] oc_inc;
  logic [IROW_W-1:0] row_inc;
  bkc_ctl_t          ctl;

  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_c_q;
  logic [PIX_W-1:0]  s1_pix_q;
  bkc_ctl_t          s1_ctl_q;
  logic [2*PIX_W-1:0] rd_data;
  pix_col_t          new_col;
  pix_col_t          cell_col [KERNEL_SIZE];

  logic              k_valid, k_last;
  logic [PIX_W-1:0]  k_pixel;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_pixel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_low_q  <= '0;
      coef_mid_q  <= 64'd256;
      coef_last_q <= '0;
      mode_q      <= BM_ZERO;
      width_q     <= WREG_W'(512);
      height_q    <= HREG_W'(512);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_LOW:  coef_low_q  <= cfg_data_i;
        REG_COEF_MID:  coef_mid_q  <= cfg_data_i;
        REG_COEF_LAST: coef_last_q <= cfg_data_i[COEF_W-1:0];
        REG_BORDER:    mode_q      <= cfg_data_i[1:0];
        REG_WIDTH:     width_q     <= cfg_data_i[WREG_W-1:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WREG_W'(2)) begin
      w_eff = WREG_W'(2);
    end else if (width_q > WREG_W'(MAX_WIDTH)) begin
      w_eff = WREG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < HREG_W'(2)) ? HREG_W'(2) : height_q;
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_frame = in_row_q < IROW_W'(h_eff);
    act      = fire && !(in_frame && s_axis_tuser);
    c        = (in_col_q >= ICOL_W'(w_eff)) ? '0 : in_col_q[ADDR_W-1:0];
    pix      = in_frame ? s_axis_tdata : '0;
    ctl.emit = (in_row_q >= IROW_W'(2)) || (in_row_q == IROW_W'(1) && c != '0);
    ctl.last = ctl.emit && (OROW_W'(out_row_q + 1'b1) >= h_eff || out_row_q == '1)
               && (ICOL_W'(out_col_q) + 1'b1 >= ICOL_W'(w_eff));
    ctl.top  = out_row_q == '0;
    ctl.bot  = ({1'b0, out_row_q} + 1'b1) >= {1'b0, h_eff};
    ctl.lok  = out_col_q != '0;
    ctl.rok  = (ICOL_W'(out_col_q) + 1'b1) < ICOL_W'(w_eff);

    c_inc   = ICOL_W'(c) + 1'b1;
    oc_inc  = ICOL_W'(out_col_q) + 1'b1;
    row_inc = in_row_q + 1'b1;

    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (cfg_valid_i && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT)) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (act) begin
      if (ctl.last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else begin
        if (ctl.emit) begin
          if (oc_inc >= ICOL_W'(w_eff)) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = oc_inc[ADDR_W-1:0];
          end
        end
        if (c_inc >= ICOL_W'(w_eff)) begin
          in_col_d = '0;
          in_row_d = row_inc;
        end else begin
          in_col_d = c_inc;
        end
        if (in_row_d > IROW_W'(h_eff) + 1'b1) begin
          in_row_d  = '0;
          in_col_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_c_q   <= c;
      s1_pix_q <= pix;
      s1_ctl_q <= ctl;
    end
  end

  bkc_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (act),
    .rd_addr_i (c),
    .rd_data_o (rd_data),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_c_q),
    .wr_data_i ({s1_pix_q, rd_data[2*PIX_W-1:PIX_W]})
  );

  assign new_col = {s1_pix_q, rd_data[2*PIX_W-1:PIX_W], rd_data[PIX_W-1:0]};
  assign cell_col[0] = new_col;

  for (genvar g = 0; g < KERNEL_SIZE - 1; g++) begin : g_cells
    bkc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en && s1_valid_q),
      .col_i  (cell_col[g]),
      .col_o  (cell_col[g+1])
    );
  end

  bkc_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s1_valid_q),
    .ctl_i       (s1_ctl_q),
    .lcol_i      (cell_col[2]),
    .ccol_i      (cell_col[1]),
    .rcol_i      (cell_col[0]),
    .coef_low_i  (coef_low_q),
    .coef_mid_i  (coef_mid_q),
    .coef_last_i (coef_last_q),
    .mode_i      (mode_q),
    .valid_o     (k_valid),
    .last_o      (k_last),
    .pixel_o     (k_pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      out_valid_q <= k_valid;
      out_last_q  <= k_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pixel_q <= k_pixel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;
  assign m_axis_tlast  = out_last_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && ctl.last) |=> (in_row_q == '0 && in_col_q == '0 && out_row_q == '0))
    else $error("counters not cleared after frame end");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ICOL_W'(out_col_q) < ICOL_W'(w_eff)))
    else $error("output column beyond width");

  a_no_emit_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && in_row_q == '0) |-> !ctl.emit)
    else $error("output emitted during first row");

endmodule
